/* sv/dfa_table_acceptor_core_defines.svh */
// Assertion macros used by the acceptor's port-level checker.
`ifndef DFA_TABLE_ACCEPTOR_CORE_DEFINES_SVH
`define DFA_TABLE_ACCEPTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dta: same-cycle property violated");

// Next-cycle implication, sampled on clk, off during reset.
`define DTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dta: next-cycle property violated");

`endif

/* sv/dta_pkg.sv */
// Shared types and constants for the table-driven DFA acceptor.
`timescale 1ns / 1ps

package dta_pkg;

    localparam int STATE_W         = 4;
    localparam int SYM_W           = 8;
    localparam int OP_W            = 2;
    localparam int MASK_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_STATES      = 1 << STATE_W;
    localparam int NUM_STATES_DEF  = 16;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_FEED   = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef struct packed {
        logic               vld;
        logic [STATE_W-1:0] nxt;
    } entry_t;

    typedef struct packed {
        logic [STATE_W-1:0] cur;
        logic               live;
        logic               at_start;
    } dfa_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctl_t;

endpackage

/* sv/dta_table.sv */
// Transition table memory with post-reset clearing sweep.
`timescale 1ns / 1ps

module dta_table
    import dta_pkg::*;
#(
    parameter  int NUM_STATES  = NUM_STATES_DEF,
    parameter  int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int TBL_STATES  = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES,
    localparam int IDX_BITS    = $clog2(TBL_STATES),
    localparam int ADDR_BITS   = IDX_BITS + SYMBOL_BITS,
    localparam int DEPTH       = TBL_STATES << SYMBOL_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbl_ctl_t             ctl,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  entry_t               wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output entry_t               rd_data,
    output logic                 busy
);

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

    entry_t                 mem [DEPTH];
    entry_t                 rd_data_reg;
    logic                   clearing_reg;
    logic                   clearing_next;
    logic [ADDR_BITS-1:0]   clr_cnt_reg;
    logic [ADDR_BITS-1:0]   clr_cnt_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

/* sv/dta_engine.sv */
// Lookup stage, automaton state, and output register of the acceptor.
`timescale 1ns / 1ps

module dta_engine
    import dta_pkg::*;
#(
    parameter  int NUM_STATES  = NUM_STATES_DEF,
    parameter  int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int TBL_STATES  = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES,
    localparam int IDX_BITS    = $clog2(TBL_STATES),
    localparam int ADDR_BITS   = IDX_BITS + SYMBOL_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [STATE_W-1:0]   from_state,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [STATE_W-1:0]   to_state,
    input  logic                 to_valid,
    input  logic                 last,
    input  logic [STATE_W-1:0]   start_state,
    input  logic [MASK_W-1:0]    final_mask,
    input  logic                 tbl_busy,
    output tbl_ctl_t             tbl_ctl,
    output logic [ADDR_BITS-1:0] wr_addr,
    output entry_t               wr_data,
    output logic [ADDR_BITS-1:0] rd_addr,
    input  entry_t               rd_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATE_W-1:0]   state_now,
    output logic                 alive,
    output logic                 word_done,
    output logic                 accepted
);

    localparam logic [STATE_W:0] TBL_LIMIT = (STATE_W + 1)'(TBL_STATES);

    logic               s2_vld_reg;
    logic               s2_vld_next;
    op_t                s2_op_reg;
    logic               s2_last_reg;
    dfa_state_t         arch_reg;
    dfa_state_t         arch_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [STATE_W-1:0] out_state_reg;
    logic               out_alive_reg;
    logic               out_done_reg;
    logic               out_acc_reg;

    logic               out_load;
    logic               s2_adv;
    logic               in_xfer;
    dfa_state_t         work;
    dfa_state_t         post;
    dfa_state_t         pre;
    logic               done;
    logic [STATE_W-1:0] look_state;
    op_t                in_op;

    assign in_op    = op_t'(operation);
    assign out_load = !out_vld_reg || out_ready;
    assign s2_adv   = s2_vld_reg && out_load;
    assign in_ready = !tbl_busy && (!s2_vld_reg || out_load);
    assign in_xfer  = in_valid && in_ready;

    // resolve the item in the lookup stage against the table read data
    always_comb
    begin
        work = arch_reg;
        done = 1'b0;
        unique case (s2_op_reg)
            OP_FEED, OP_FINISH:
            begin
                if (work.at_start)
                begin
                    work.cur      = start_state;
                    work.live     = 1'b1;
                    work.at_start = 1'b0;
                end
                if ((s2_op_reg == OP_FEED) && work.live)
                begin
                    if (({1'b0, work.cur} < TBL_LIMIT) && rd_data.vld)
                    begin
                        work.cur = rd_data.nxt;
                    end
                    else
                    begin
                        work.live = 1'b0;
                    end
                end
                done = (s2_op_reg == OP_FINISH) || s2_last_reg;
            end
            default:
            begin
            end
        endcase
        post = work;
        if (done)
        begin
            post.cur      = start_state;
            post.live     = 1'b1;
            post.at_start = 1'b1;
        end
    end

    // state seen by the incoming item: forwarded from the lookup stage when it holds an item, else the held state
    assign pre        = s2_vld_reg ? post : arch_reg;
    assign look_state = pre.at_start ? start_state : pre.cur;

    assign rd_addr = {look_state[IDX_BITS-1:0], symbol[SYMBOL_BITS-1:0]};
    assign wr_addr = {from_state[IDX_BITS-1:0], symbol[SYMBOL_BITS-1:0]};
    assign wr_data = '{vld: to_valid, nxt: to_state};

    always_comb
    begin
        tbl_ctl.wr_en = in_xfer && (in_op == OP_WRITE) && ({1'b0, from_state} < TBL_LIMIT);
        tbl_ctl.rd_en = in_xfer && (in_op == OP_FEED);
    end

    always_comb
    begin
        s2_vld_next = s2_vld_reg;
        if (in_xfer)
        begin
            s2_vld_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_vld_next = 1'b0;
        end
        arch_next = s2_adv ? post : arch_reg;
        out_vld_next = out_vld_reg;
        if (s2_adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            arch_reg    <= '{cur: '0, live: 1'b1, at_start: 1'b1};
        end
        else
        begin
            s2_vld_reg  <= s2_vld_next;
            out_vld_reg <= out_vld_next;
            arch_reg    <= arch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s2_op_reg   <= in_op;
            s2_last_reg <= last;
        end
        if (s2_adv)
        begin
            out_state_reg <= work.cur;
            out_alive_reg <= work.live;
            out_done_reg  <= done;
            out_acc_reg   <= done && work.live && final_mask[work.cur];
        end
    end

    assign out_valid = out_vld_reg;
    assign state_now = out_state_reg;
    assign alive     = out_alive_reg;
    assign word_done = out_done_reg;
    assign accepted  = out_acc_reg;

endmodule

/* sv/dfa_table_acceptor_core.sv */
// Top level of the table-driven DFA word acceptor.
`timescale 1ns / 1ps

// Takes one item per cycle while the table sweep is done and the output side
// is ready, and returns one result per item through the lookup stage and the
// output register. The rate is set by the loop from the transition table's
// registered read data through next-state selection to the next read address.
// After reset the table is swept to all-invalid, one entry per cycle, over
// min(NUM_STATES,16) << SYMBOL_BITS entries (4096 by default); in_ready stays
// low during the sweep while configuration writes are still taken.
module dfa_table_acceptor_core
    import dta_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [STATE_W-1:0]   from_state,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [STATE_W-1:0]   to_state,
    input  logic                 to_valid,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATE_W-1:0]   state_now,
    output logic                 alive,
    output logic                 word_done,
    output logic                 accepted
);

    localparam int TBL_STATES = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES;
    localparam int ADDR_BITS  = $clog2(TBL_STATES) + SYMBOL_BITS;

    logic [STATE_W-1:0]   start_state_reg;
    logic [STATE_W-1:0]   start_state_next;
    logic [MASK_W-1:0]    final_mask_reg;
    logic [MASK_W-1:0]    final_mask_next;

    tbl_ctl_t             tbl_ctl;
    logic [ADDR_BITS-1:0] wr_addr;
    entry_t               wr_data;
    logic [ADDR_BITS-1:0] rd_addr;
    entry_t               rd_data;
    logic                 tbl_busy;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_state_next = start_state_reg;
        final_mask_next  = final_mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_STATE: start_state_next = cfg_data[STATE_W-1:0];
                CFG_FINAL_MASK:  final_mask_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
        end
        else
        begin
            start_state_reg <= start_state_next;
            final_mask_reg  <= final_mask_next;
        end
    end

    dta_table #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tbl_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (tbl_busy)
    );

    dta_engine #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .from_state  (from_state),
        .symbol      (symbol),
        .to_state    (to_state),
        .to_valid    (to_valid),
        .last        (last),
        .start_state (start_state_reg),
        .final_mask  (final_mask_reg),
        .tbl_busy    (tbl_busy),
        .tbl_ctl     (tbl_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .state_now   (state_now),
        .alive       (alive),
        .word_done   (word_done),
        .accepted    (accepted)
    );

endmodule

/* sv/dta_checker.sv */
// Port-level assertion checker for the acceptor, bound to the top level.
`timescale 1ns / 1ps

`include "dfa_table_acceptor_core_defines.svh"

module dta_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] state_now,
    input logic       alive,
    input logic       word_done,
    input logic       accepted
);

    // stalled result holds
    `DTA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({state_now, alive, word_done, accepted}))

    // acceptance only on a live word end
    `DTA_ASSERT_IMP(a_acc_live_done, out_valid && accepted, word_done && alive)

    // a transfer into a stalled pipe fills it; no second transfer until output drains
    `DTA_ASSERT_NXT(a_fill_stall, in_valid && in_ready && out_valid && !out_ready, !in_ready || out_ready)

endmodule

bind dfa_table_acceptor_core dta_checker u_dta_checker (.*);

/* sim/dfa_verdict_checker.sv */
// Checker for the DFA acceptor: tracks table and word state, compares every result.
`timescale 1ns / 1ps

module dfa_verdict_checker
    import dta_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [STATE_W-1:0]   from_state,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [STATE_W-1:0]   to_state,
    input  logic                 to_valid,
    input  logic                 last,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [STATE_W-1:0]   state_now,
    input  logic                 alive,
    input  logic                 word_done,
    input  logic                 accepted,
    output int                   pending,
    output int                   fail_count
);

    localparam int TBL_DEPTH = NUM_STATES << SYMBOL_BITS;
    localparam int SYM_MASK  = (1 << SYMBOL_BITS) - 1;

    typedef struct packed {
        logic [STATE_W-1:0] state_now;
        logic               alive;
        logic               word_done;
        logic               accepted;
    } verdict_t;

    entry_t             trans_tbl [0:TBL_DEPTH-1];
    logic [STATE_W-1:0] cur_state;
    logic               word_live;
    logic               word_fresh;
    logic [STATE_W-1:0] start_reg;
    logic [MASK_W-1:0]  accept_mask;
    verdict_t           expected_verdicts [$];

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    function automatic int tbl_addr(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] sym);
        return (int'(st) << SYMBOL_BITS) | (int'(sym) & SYM_MASK);
    endfunction

    function automatic verdict_t advance_dfa(
        input logic [OP_W-1:0]    op,
        input logic [STATE_W-1:0] src,
        input logic [SYM_W-1:0]   sym,
        input logic [STATE_W-1:0] dst,
        input logic               dst_ok,
        input logic               ends_word
    );
        verdict_t v;
        entry_t   e;
        logic     done;
        done = 1'b0;
        case (op)
            OP_WRITE: begin
                if (int'(src) < NUM_STATES)
                    trans_tbl[tbl_addr(src, sym)] = '{vld: dst_ok, nxt: dst};
            end
            OP_FEED, OP_FINISH: begin
                if (word_fresh) begin
                    cur_state  = start_reg;
                    word_live  = 1'b1;
                    word_fresh = 1'b0;
                end
                if (op == OP_FEED && word_live) begin
                    if (int'(cur_state) < NUM_STATES) begin
                        e = trans_tbl[tbl_addr(cur_state, sym)];
                        if (e.vld)
                            cur_state = e.nxt;
                        else
                            word_live = 1'b0;
                    end
                    else begin
                        word_live = 1'b0;
                    end
                end
                done = (op == OP_FINISH) || ends_word;
            end
            default: ;
        endcase
        v.state_now = cur_state;
        v.alive     = word_live;
        v.word_done = done;
        v.accepted  = done && word_live && accept_mask[cur_state];
        if (done) begin
            cur_state  = start_reg;
            word_live  = 1'b1;
            word_fresh = 1'b1;
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        if (!rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++)
                trans_tbl[i] = '0;
            cur_state   = '0;
            word_live   = 1'b1;
            word_fresh  = 1'b1;
            start_reg   = '0;
            accept_mask = '0;
            expected_verdicts.delete();
            pending = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_STATE: start_reg   = cfg_data[STATE_W-1:0];
                    CFG_FINAL_MASK:  accept_mask = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                want = advance_dfa(operation, from_state, symbol, to_state, to_valid, last);
                expected_verdicts = {expected_verdicts, want};
            end
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end
                else begin
                    want = expected_verdicts.pop_front();
                    check_field("state_now", 8'(want.state_now), 8'(state_now));
                    check_field("alive", 8'(want.alive), 8'(alive));
                    check_field("word_done", 8'(want.word_done), 8'(word_done));
                    check_field("accepted", 8'(want.accepted), 8'(accepted));
                end
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

/* sim/tb_dfa_table_acceptor_core.sv */
// Testbench top for the DFA acceptor: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module tb_dfa_table_acceptor_core;
    import dta_pkg::*;

    localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                   HOLD_CYCLES = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      operation;
    logic [STATE_W-1:0]   from_state;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   to_state;
    logic                 to_valid;
    logic                 last;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATE_W-1:0]   state_now;
    logic                 alive;
    logic                 word_done;
    logic                 accepted;
    int                   pending;
    int                   fail_count;

    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   hold_reqs;
    int                   hold_served;
    int                   hold_left;
    int                   items_sent;
    logic [SYM_W-1:0]     alphabet [4];

    dfa_table_acceptor_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .from_state (from_state),
        .symbol     (symbol),
        .to_state   (to_state),
        .to_valid   (to_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .state_now  (state_now),
        .alive      (alive),
        .word_done  (word_done),
        .accepted   (accepted)
    );

    dfa_verdict_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .from_state (from_state),
        .symbol     (symbol),
        .to_state   (to_state),
        .to_valid   (to_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .state_now  (state_now),
        .alive      (alive),
        .word_done  (word_done),
        .accepted   (accepted),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls plus one long hold-off per request
    initial begin
        out_ready   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served != hold_reqs) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Called at a falling edge; leaves cfg_valid high for a following write.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [STATE_W-1:0] start_val,
                                input logic [MASK_W-1:0] mask_val);
        put_reg(CFG_START_STATE, MASK_W'(start_val));
        put_reg(CFG_FINAL_MASK, mask_val);
        cfg_valid <= 1'b0;
    endtask

    // Called at a falling edge; leaves in_valid high so the next item follows without a gap.
    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [STATE_W-1:0] src,
        input logic [SYM_W-1:0]   sym,
        input logic [STATE_W-1:0] dst,
        input logic               dst_ok,
        input logic               ends_word
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        from_state <= src;
        symbol     <= sym;
        to_state   <= dst;
        to_valid   <= dst_ok;
        last       <= ends_word;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input logic [STATE_W-1:0] start_val,
                             input logic [MASK_W-1:0] mask_val, input int quota);
        int               stop_at;
        int               len;
        bit               by_last;
        logic [SYM_W-1:0] sym;
        drain();
        program_regs(start_val, mask_val);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = items_sent + quota;
        for (int k = 0; k < 4; k++)
            alphabet[k] = SYM_W'($urandom_range(255));
        for (int s = 0; s < 16; s++)
            for (int k = 0; k < 4; k++)
                send_item(OP_WRITE, STATE_W'(s), alphabet[k], STATE_W'($urandom_range(15)),
                          $urandom_range(99) < 90, 1'($urandom_range(1)));
        hold_reqs++;
        while (items_sent < stop_at) begin
            len     = int'($urandom_range(8));
            by_last = (len > 0) && ($urandom_range(99) < 70);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 6) begin
                    if ($urandom_range(1))
                        send_item(OP_RESERVED, STATE_W'($urandom_range(15)),
                                  SYM_W'($urandom_range(255)), STATE_W'($urandom_range(15)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    else
                        send_item(OP_WRITE, STATE_W'($urandom_range(15)),
                                  alphabet[2'($urandom_range(3))],
                                  STATE_W'($urandom_range(15)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                sym = ($urandom_range(99) < 92) ? alphabet[2'($urandom_range(3))]
                                                : SYM_W'($urandom_range(255));
                send_item(OP_FEED, STATE_W'($urandom_range(15)), sym,
                          STATE_W'($urandom_range(15)), 1'($urandom_range(1)),
                          by_last && (k == len - 1));
            end
            if (!by_last)
                send_item(OP_FINISH, STATE_W'($urandom_range(15)), SYM_W'($urandom_range(255)),
                          STATE_W'($urandom_range(15)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = '0;
        from_state  = '0;
        symbol      = '0;
        to_state    = '0;
        to_valid    = 1'b0;
        last        = 1'b0;
        tx_idle_pct = 24;
        rx_idle_pct = 50;
        hold_reqs   = 0;
        items_sent  = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_reg(CFG_SPARE, MASK_W'($urandom_range(16'hFFFF)));
        program_regs(4'd15, 16'h0000);
        // empty word with no accepting states
        send_item(OP_FINISH, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        drain();
        program_regs(4'd15, 16'h8001);
        send_item(OP_FINISH, 4'd15, 8'd255, 4'd15, 1'b1, 1'b1);
        send_item(OP_WRITE, 4'd15, 8'd0, 4'd0, 1'b1, 1'b0);
        send_item(OP_WRITE, 4'd0, 8'd255, 4'd15, 1'b1, 1'b1);
        send_item(OP_WRITE, 4'd15, 8'd255, 4'd7, 1'b0, 1'b0);
        send_item(OP_WRITE, 4'd0, 8'h55, 4'd10, 1'b1, 1'b0);
        send_item(OP_FEED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_FEED, 4'd15, 8'd255, 4'd15, 1'b1, 1'b1);
        // dead word: missing transition, then feeds that do nothing
        send_item(OP_FEED, 4'd0, 8'd255, 4'd0, 1'b0, 1'b0);
        send_item(OP_FEED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_RESERVED, 4'd15, 8'd255, 4'd15, 1'b1, 1'b1);
        send_item(OP_FINISH, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        // table write in the middle of a word
        send_item(OP_FEED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_WRITE, 4'd0, 8'h55, 4'd3, 1'b1, 1'b0);
        send_item(OP_FEED, 4'd0, 8'h55, 4'd0, 1'b0, 1'b1);
        send_item(OP_FEED, 4'd0, 8'h12, 4'd0, 1'b0, 1'b1);
        send_item(OP_RESERVED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_FEED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_RESERVED, 4'd0, 8'd0, 4'd0, 1'b0, 1'b0);
        send_item(OP_FEED, 4'd0, 8'd255, 4'd0, 1'b0, 1'b1);

        run_phase(24, 50, 4'd0, 16'hFFFF, 330);
        run_phase(50, 24, 4'd15, MASK_W'($urandom_range(16'hFFFF)), 330);
        run_phase(0, 0, STATE_W'($urandom_range(15)), MASK_W'($urandom_range(16'hFFFF)), 330);

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/dta_pkg.sv
sv/dta_table.sv
sv/dta_engine.sv
sv/dfa_table_acceptor_core.sv
sv/dta_checker.sv
sim/dfa_verdict_checker.sv
sim/tb_dfa_table_acceptor_core.sv
